FILE: hw/rtl/bsmt_pkg.sv
`timescale 1ns / 1ps

package bsmt_pkg;

    // default geometry and history depth
    localparam int DEF_MAX_WIDTH      = 640;
    localparam int DEF_MAX_HEIGHT     = 480;
    localparam int DEF_HISTORY_FRAMES = 10;

    // configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_HEIGHT    = 2'd2;

    // configuration reset values
    localparam logic [7:0] THR_RST    = 8'd100;
    localparam logic [9:0] WIDTH_RST  = 10'd640;
    localparam logic [8:0] HEIGHT_RST = 9'd480;

    // input op codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // gray weights, 14-bit fixed point
    localparam logic [12:0] W_RED   = 13'd4899;
    localparam logic [13:0] W_GREEN = 14'd9617;
    localparam logic [10:0] W_BLUE  = 11'd1868;
    localparam logic [21:0] W_ROUND = 22'd8192;

    typedef struct packed {
        logic       op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       is_detection;
        logic       frame_end;
    } out_beat_t;

    // per-item window control carried down the pipe
    typedef struct packed {
        logic det;      // detection mode for this item
        logic take;     // item is a real pixel of the frame
        logic emit_col; // column-zero result from the shifted old window
        logic last;     // that result closes the frame
        logic load;     // reload window at start of a row
        logic shift;    // shift in a new column and emit
        logic par;      // parity of the current row
        logic top_mid;  // top row replicates the middle row
    } win_ctl_t;

    typedef logic [8:0][7:0] med_vec_t;

    // median-of-nine exchange network
    localparam int MED_N = 19;
    localparam int MED_SPLIT = 12;
    localparam int MED_LO [MED_N] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
    localparam int MED_HI [MED_N] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

    // first part of the network
    function automatic med_vec_t med_front(input med_vec_t v);
        med_vec_t w;
        logic [7:0] t;
        w = v;
        for (int k = 0; k < MED_SPLIT; k++) begin
            if (w[MED_LO[k]] > w[MED_HI[k]]) begin
                t = w[MED_LO[k]];
                w[MED_LO[k]] = w[MED_HI[k]];
                w[MED_HI[k]] = t;
            end
        end
        return w;
    endfunction

    // remaining exchanges, median ends in slot four
    function automatic logic [7:0] med_back(input med_vec_t v);
        med_vec_t w;
        logic [7:0] t;
        w = v;
        for (int k = MED_SPLIT; k < MED_N; k++) begin
            if (w[MED_LO[k]] > w[MED_HI[k]]) begin
                t = w[MED_LO[k]];
                w[MED_LO[k]] = w[MED_HI[k]];
                w[MED_HI[k]] = t;
            end
        end
        return w[4];
    endfunction

endpackage

FILE: hw/rtl/background_subtract_median_threshold.sv
`timescale 1ns / 1ps
// pipeline: after the input beat that completes it, a result beat passes stages
// b to f into the output register; results follow one row and one pixel behind
// throughput: one beat per cycle unless m_ready stalls, set by history/sum ports
// reset: aresetn synchronous active low; afterwards a clearing pass zeroes the
// running sums at every pixel address, with s_ready low (config still taken)
module background_subtract_median_threshold #(
    parameter int MAX_WIDTH      = bsmt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = bsmt_pkg::DEF_MAX_HEIGHT,
    parameter int HISTORY_FRAMES = bsmt_pkg::DEF_HISTORY_FRAMES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bsmt_pkg::in_beat_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bsmt_pkg::out_beat_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [9:0]         cfg_data
);
    import bsmt_pkg::*;

    localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
    localparam int PA     = $clog2(PIXELS);
    localparam int HA     = $clog2(HISTORY_FRAMES * PIXELS);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int CW1    = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_HEIGHT + 2);
    localparam int RBW    = $clog2((MAX_HEIGHT + 2) * MAX_WIDTH);
    localparam int FW     = $clog2(HISTORY_FRAMES + 1);
    localparam int SW     = $clog2(HISTORY_FRAMES);
    localparam int DIV_SH = 24;
    localparam int RECIP  = ((1 << DIV_SH) + HISTORY_FRAMES - 1) / HISTORY_FRAMES;
    localparam int FW_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int FH_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    // memories
    logic [11:0] sum_mem  [PIXELS];
    logic [7:0]  hist_mem [HISTORY_FRAMES * PIXELS];
    logic [31:0] line_mem [MAX_WIDTH];

    // configuration
    logic [7:0] thr_reg;
    logic [9:0] aw_reg;
    logic [8:0] ah_reg;

    // frame control
    logic [RW-1:0]  row_reg,    row_next;
    logic [CW-1:0]  col_reg,    col_next;
    logic [RBW-1:0] rowb_reg,   rowb_next;
    logic [FW-1:0]  frames_reg, frames_next;
    logic [SW-1:0]  slot_reg,   slot_next;
    logic [HA-1:0]  slotb_reg,  slotb_next;
    logic [CW1-1:0] fw_reg,     fw_next;
    logic [RW-1:0]  fh_reg,     fh_next;

    // clearing pass
    logic          clr_reg;
    logic [PA-1:0] clr_addr_reg;

    logic adv, acc;

    // stage b: memory data ready
    logic          b_valid_reg;
    win_ctl_t      b_ctl_reg;
    logic [7:0]    b_gray_reg;
    logic [PA-1:0] b_pix_reg;
    logic [HA-1:0] b_hist_reg;
    logic [CW-1:0] b_col_reg;
    logic [11:0]   sum_q_reg;
    logic [7:0]    hist_q_reg;

    // stage c: saturated sum
    logic          c_valid_reg;
    win_ctl_t      c_ctl_reg;
    logic [7:0]    c_gray_reg;
    logic [11:0]   c_s_reg;
    logic [CW-1:0] c_col_reg;

    // stage d: quotient and line data
    logic          d_valid_reg;
    win_ctl_t      d_ctl_reg;
    logic [7:0]    d_gray_reg;
    logic [11:0]   d_s_reg;
    logic [11:0]   d_q_reg;
    logic [CW-1:0] d_col_reg;
    logic [31:0]   line_q_reg;

    logic [8:0][15:0] win_reg, win_next;

    // stage e: window snapshot
    logic       e_valid_reg;
    logic       e_det_reg, e_last_reg;
    logic [7:0] e_gray_reg;
    med_vec_t   e_v_reg;

    // stage f: partly sorted
    logic       f_valid_reg;
    logic       f_det_reg, f_last_reg;
    logic [7:0] f_gray_reg;
    med_vec_t   f_v_reg;

    logic      m_valid_reg;
    out_beat_t m_data_reg;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv && !clr_reg;
    assign acc       = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // clamped frame size from the registers
    logic [CW1-1:0] fw_cfg;
    logic [RW-1:0]  fh_cfg;
    always_comb begin
        if (aw_reg < 10'd3) begin
            fw_cfg = CW1'(3);
        end else if (16'(aw_reg) > 16'(MAX_WIDTH)) begin
            fw_cfg = CW1'(MAX_WIDTH);
        end else begin
            fw_cfg = CW1'(aw_reg);
        end
        if (ah_reg < 9'd3) begin
            fh_cfg = RW'(3);
        end else if (16'(ah_reg) > 16'(MAX_HEIGHT)) begin
            fh_cfg = RW'(MAX_HEIGHT);
        end else begin
            fh_cfg = RW'(ah_reg);
        end
    end

    // gray conversion on the input beat
    logic [21:0] gray_acc;
    logic [7:0]  gray_a;
    assign gray_acc = 22'(s_data.red) * 22'(W_RED) + 22'(s_data.green) * 22'(W_GREEN)
                    + 22'(s_data.blue) * 22'(W_BLUE) + W_ROUND;
    assign gray_a = gray_acc[21:14];

    // per-item raster control
    logic           pre_close, drop, start, take_a, use_a;
    logic [FW-1:0]  fr_e;
    logic [SW-1:0]  slot_e;
    logic [HA-1:0]  slotb_e;
    logic [RW-1:0]  r0;
    logic [CW-1:0]  c0;
    logic [RBW-1:0] rb0;
    logic [CW1-1:0] fw_e, c_inc;
    logic [RW-1:0]  fh_e;
    logic [RBW-1:0] pix_full;
    logic [PA-1:0]  pix_a;
    logic [HA-1:0]  hist_a;
    win_ctl_t       ctl_a;

    always_comb begin
        pre_close = (s_data.op == OP_PIXEL) && (row_reg >= fh_reg);
        drop      = (s_data.op == OP_FLUSH) && (row_reg < fh_reg);
        fr_e    = frames_reg;
        slot_e  = slot_reg;
        slotb_e = slotb_reg;
        if (pre_close) begin
            if (frames_reg < FW'(HISTORY_FRAMES)) fr_e = frames_reg + FW'(1);
            if (slot_reg == SW'(HISTORY_FRAMES - 1)) begin
                slot_e  = '0;
                slotb_e = '0;
            end else begin
                slot_e  = slot_reg + SW'(1);
                slotb_e = slotb_reg + HA'(PIXELS);
            end
        end
        r0  = pre_close ? '0 : row_reg;
        c0  = pre_close ? '0 : col_reg;
        rb0 = pre_close ? '0 : rowb_reg;
        start = (s_data.op == OP_PIXEL) && (r0 == '0) && (c0 == '0);
        fw_e  = start ? fw_cfg : fw_reg;
        fh_e  = start ? fh_cfg : fh_reg;

        take_a = r0 < fh_e;
        use_a  = (r0 >= RW'(1)) && (r0 <= fh_e);
        ctl_a.det      = fr_e >= FW'(HISTORY_FRAMES);
        ctl_a.take     = take_a;
        ctl_a.emit_col = (c0 == '0) && (r0 >= RW'(2));
        ctl_a.last     = r0 == fh_e + RW'(1);
        ctl_a.load     = use_a && (c0 == '0);
        ctl_a.shift    = use_a && (c0 != '0);
        ctl_a.par      = r0[0];
        ctl_a.top_mid  = r0 < RW'(2);

        pix_full = rb0 + RBW'(c0);
        pix_a    = pix_full[PA-1:0];
        hist_a   = slotb_e + HA'(pix_a);

        // state after this item
        frames_next = fr_e;
        slot_next   = slot_e;
        slotb_next  = slotb_e;
        fw_next     = fw_e;
        fh_next     = fh_e;
        c_inc       = CW1'(c0) + CW1'(1);
        if (r0 > fh_e) begin
            row_next  = '0;
            col_next  = '0;
            rowb_next = '0;
            if (fr_e < FW'(HISTORY_FRAMES)) frames_next = fr_e + FW'(1);
            if (slot_e == SW'(HISTORY_FRAMES - 1)) begin
                slot_next  = '0;
                slotb_next = '0;
            end else begin
                slot_next  = slot_e + SW'(1);
                slotb_next = slotb_e + HA'(PIXELS);
            end
        end else if (c_inc >= fw_e) begin
            row_next  = r0 + RW'(1);
            col_next  = '0;
            rowb_next = rb0 + RBW'(MAX_WIDTH);
        end else begin
            row_next  = r0;
            col_next  = c_inc[CW-1:0];
            rowb_next = rb0;
        end
    end

    // configuration, frame control and clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= THR_RST;
            aw_reg       <= WIDTH_RST;
            ah_reg       <= HEIGHT_RST;
            row_reg      <= '0;
            col_reg      <= '0;
            rowb_reg     <= '0;
            frames_reg   <= '0;
            slot_reg     <= '0;
            slotb_reg    <= '0;
            fw_reg       <= CW1'(FW_RST);
            fh_reg       <= RW'(FH_RST);
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_THRESHOLD: thr_reg <= cfg_data[7:0];
                    CFG_WIDTH:     aw_reg  <= cfg_data;
                    CFG_HEIGHT:    ah_reg  <= cfg_data[8:0];
                    default:       ;
                endcase
            end
            if (acc && !drop) begin
                row_reg    <= row_next;
                col_reg    <= col_next;
                rowb_reg   <= rowb_next;
                frames_reg <= frames_next;
                slot_reg   <= slot_next;
                slotb_reg  <= slotb_next;
                fw_reg     <= fw_next;
                fh_reg     <= fh_next;
            end
            if (clr_reg) begin
                if (clr_addr_reg == PA'(PIXELS - 1)) clr_reg <= 1'b0;
                clr_addr_reg <= clr_addr_reg + PA'(1);
            end
        end
    end

    // stage b: running sum update
    logic signed [13:0] s_raw;
    logic [11:0]        s_sat;
    always_comb begin
        s_raw = $signed({2'b00, sum_q_reg}) + $signed({6'b0, b_gray_reg})
              - $signed({6'b0, (b_ctl_reg.det ? hist_q_reg : 8'd0)});
        if (s_raw < 0) begin
            s_sat = '0;
        end else if (s_raw > 14'sd4095) begin
            s_sat = 12'd4095;
        end else begin
            s_sat = s_raw[11:0];
        end
    end

    // history and sum memories: read at accept, written back from stage b
    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_q_reg  <= sum_mem[pix_a];
            hist_q_reg <= hist_mem[hist_a];
        end
        if (clr_reg) begin
            sum_mem[clr_addr_reg] <= '0;
        end else if (adv && b_valid_reg && b_ctl_reg.take) begin
            sum_mem[b_pix_reg] <= s_sat;
        end
        if (adv && b_valid_reg && b_ctl_reg.take) begin
            hist_mem[b_hist_reg] <= b_gray_reg;
        end
    end

    // stage c: reciprocal multiply for the average
    logic [36:0] prod_c;
    assign prod_c = 37'(c_s_reg) * 37'(RECIP);

    // stage d: remainder, rounding, difference
    logic [11:0] qh_d, rem_full;
    logic [5:0]  rem2;
    logic [12:0] avg_q;
    logic [7:0]  avg_d, diff_d;
    logic [15:0] cur_d, mid_d, top_d, bot_d;
    logic [31:0] line_wr;
    med_vec_t    snap_v;
    logic [8:0][15:0] snap_w;

    always_comb begin
        qh_d     = 12'(d_q_reg * 12'(HISTORY_FRAMES));
        rem_full = d_s_reg - qh_d;
        rem2     = {rem_full[4:0], 1'b0};
        avg_q    = {1'b0, d_q_reg};
        if (rem2 > 6'(HISTORY_FRAMES) || (rem2 == 6'(HISTORY_FRAMES) && d_q_reg[0])) begin
            avg_q = avg_q + 13'd1;
        end
        avg_d  = (avg_q > 13'd255) ? 8'd255 : avg_q[7:0];
        diff_d = (d_ctl_reg.det && d_gray_reg > avg_d) ? d_gray_reg - avg_d : 8'd0;
        cur_d  = {d_gray_reg, diff_d};

        // rows from the line store
        mid_d = d_ctl_reg.par ? line_q_reg[15:0] : line_q_reg[31:16];
        if (d_ctl_reg.top_mid) begin
            top_d = mid_d;
        end else begin
            top_d = d_ctl_reg.par ? line_q_reg[31:16] : line_q_reg[15:0];
        end
        bot_d   = d_ctl_reg.take ? cur_d : mid_d;
        line_wr = d_ctl_reg.par ? {cur_d, line_q_reg[15:0]} : {line_q_reg[31:16], cur_d};

        // window update
        snap_w = win_reg;
        for (int k = 0; k < 3; k++) begin
            snap_w[k*3]     = win_reg[k*3+1];
            snap_w[k*3 + 1] = win_reg[k*3+2];
        end
        if (d_ctl_reg.shift) begin
            snap_w[2] = top_d;
            snap_w[5] = mid_d;
            snap_w[8] = bot_d;
        end
        win_next = win_reg;
        if (d_ctl_reg.load) begin
            for (int k = 0; k < 3; k++) begin
                win_next[k]     = top_d;
                win_next[3 + k] = mid_d;
                win_next[6 + k] = bot_d;
            end
        end else if (d_ctl_reg.shift || d_ctl_reg.emit_col) begin
            win_next = snap_w;
        end
        for (int k = 0; k < 9; k++) snap_v[k] = snap_w[k][7:0];
    end

    // line store: read in stage c, write back in stage d
    always_ff @(posedge aclk) begin
        if (adv) begin
            line_q_reg <= line_mem[c_col_reg];
        end
        if (adv && d_valid_reg && d_ctl_reg.take) begin
            line_mem[d_col_reg] <= line_wr;
        end
    end

    // pipeline valids and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            win_reg     <= '0;
        end else if (adv) begin
            b_valid_reg <= acc && !drop;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg && (d_ctl_reg.emit_col || d_ctl_reg.shift);
            f_valid_reg <= e_valid_reg;
            m_valid_reg <= f_valid_reg;
            if (d_valid_reg) win_reg <= win_next;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            b_ctl_reg  <= ctl_a;
            b_gray_reg <= gray_a;
            b_pix_reg  <= pix_a;
            b_hist_reg <= hist_a;
            b_col_reg  <= c0;

            c_ctl_reg  <= b_ctl_reg;
            c_gray_reg <= b_gray_reg;
            c_s_reg    <= s_sat;
            c_col_reg  <= b_col_reg;

            d_ctl_reg  <= c_ctl_reg;
            d_gray_reg <= c_gray_reg;
            d_s_reg    <= c_s_reg;
            d_q_reg    <= prod_c[DIV_SH+11:DIV_SH];
            d_col_reg  <= c_col_reg;

            e_det_reg  <= d_ctl_reg.det;
            e_last_reg <= d_ctl_reg.emit_col && d_ctl_reg.last;
            e_gray_reg <= snap_w[4][15:8];
            e_v_reg    <= snap_v;

            f_det_reg  <= e_det_reg;
            f_last_reg <= e_last_reg;
            f_gray_reg <= e_gray_reg;
            f_v_reg    <= med_front(e_v_reg);

            m_data_reg.pixel_out    <= f_det_reg ? ((med_back(f_v_reg) > thr_reg) ? 8'd255 : 8'd0)
                                                 : f_gray_reg;
            m_data_reg.is_detection <= f_det_reg;
            m_data_reg.frame_end    <= f_last_reg;
        end
    end

endmodule

FILE: tb/sv/tb_background_subtract_median_threshold.sv
`timescale 1ns / 1ps

module tb_background_subtract_median_threshold;
    import bsmt_pkg::*;

    localparam int COLS     = DEF_MAX_WIDTH;
    localparam int ROWS     = DEF_MAX_HEIGHT;
    localparam int NPIX     = COLS * ROWS;
    localparam int HIST     = DEF_HISTORY_FRAMES;
    localparam int SETTLE   = 20;
    localparam int WD_LIMIT = 1500000;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_beat_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_beat_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_data = '0;

    background_subtract_median_threshold dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // stimulus and expectation stores
    in_beat_t  pixel_queue[$];
    out_beat_t expected_beats[$];
    bit        calm = 1'b0;
    int        errors = 0;
    int        checked = 0;
    int        detections = 0;
    int        frames_closed = 0;

    // detector state mirror
    byte unsigned history[int];
    int           pix_sum[int];
    int           seen_frames, slot;
    logic [15:0]  line_mem[2*COLS];
    logic [15:0]  win[9];
    int           row_ct, col_ct;
    int           thr, cfg_w, cfg_h, fw, fh;

    function automatic int clampd(int v, int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int avg_even(int s);
        int q, rm;
        q = s / HIST;
        rm = s % HIST;
        if (2 * rm > HIST || (2 * rm == HIST && q[0])) q++;
        return q > 255 ? 255 : q;
    endfunction

    function automatic int median_diff();
        int v[9];
        int t, j;
        for (int i = 0; i < 9; i++) v[i] = win[i][7:0];
        for (int i = 1; i < 9; i++) begin
            t = v[i];
            j = i;
            while (j > 0 && v[j-1] > t) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = t;
        end
        return v[4];
    endfunction

    task automatic shift_win(logic [15:0] t, logic [15:0] m, logic [15:0] b);
        for (int k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = t;
        win[5] = m;
        win[8] = b;
    endtask

    task automatic queue_result(bit last);
        out_beat_t e;
        if (seen_frames >= HIST) begin
            e.pixel_out    = median_diff() > thr ? 8'd255 : 8'd0;
            e.is_detection = 1'b1;
        end else begin
            e.pixel_out    = win[4][15:8];
            e.is_detection = 1'b0;
        end
        e.frame_end = last;
        expected_beats.insert(expected_beats.size(), e);
    endtask

    task automatic close_frame();
        if (seen_frames < HIST) seen_frames++;
        slot = (slot + 1) % HIST;
        row_ct = 0;
        col_ct = 0;
        frames_closed++;
    endtask

    function automatic logic [15:0] absorb_pixel(in_beat_t b, int r, int c);
        int gray, pix, at, old, s, a, diff;
        gray = (4899 * b.red + 9617 * b.green + 1868 * b.blue + 8192) >> 14;
        pix = r * COLS + c;
        at = slot * NPIX + pix;
        old = (seen_frames >= HIST && history.exists(at)) ? history[at] : 0;
        s = (pix_sum.exists(pix) ? pix_sum[pix] : 0) + gray - old;
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
        pix_sum[pix] = s;
        history[at] = gray;
        diff = 0;
        if (seen_frames >= HIST) begin
            a = avg_even(s);
            diff = gray > a ? gray - a : 0;
        end
        return {gray[7:0], diff[7:0]};
    endfunction

    // advance the detector by one accepted input beat
    task automatic step_detector(in_beat_t b);
        int r, c;
        logic [15:0] cur, mid, top, bot;
        cur = '0;
        if (b.op == OP_PIXEL && row_ct >= fh) close_frame();
        if (b.op == OP_FLUSH && row_ct < fh) return;
        if (b.op == OP_PIXEL && row_ct == 0 && col_ct == 0) begin
            fw = clampd(cfg_w, COLS);
            fh = clampd(cfg_h, ROWS);
        end
        r = row_ct;
        c = col_ct;
        if (c == 0 && r >= 2) begin
            shift_win(win[2], win[5], win[8]);
            queue_result(r - 2 == fh - 1);
        end
        if (r < fh) cur = absorb_pixel(b, r, c);
        if (r >= 1 && r <= fh) begin
            mid = line_mem[((r - 1) & 1) * COLS + c];
            top = r >= 2 ? line_mem[(r & 1) * COLS + c] : mid;
            bot = r < fh ? cur : mid;
            if (c == 0) begin
                for (int k = 0; k < 3; k++) begin
                    win[k] = top;
                    win[3+k] = mid;
                    win[6+k] = bot;
                end
            end else begin
                shift_win(top, mid, bot);
                queue_result(1'b0);
            end
        end
        if (r < fh) line_mem[(r & 1) * COLS + c] = cur;
        if (r > fh) begin
            close_frame();
        end else begin
            col_ct = c + 1;
            if (col_ct >= fw) begin
                col_ct = 0;
                row_ct = r + 1;
            end
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) step_detector(s_data);
            if (!s_valid || s_ready) begin
                if (pixel_queue.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
                    s_valid <= 1'b1;
                    s_data  <= pixel_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        out_beat_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected result beat, actual %p", $time, m_data);
                    errors++;
                end else begin
                    e = expected_beats.pop_front();
                    checked++;
                    if (e.is_detection && e.pixel_out == 8'd255) detections++;
                    if (m_data.pixel_out !== e.pixel_out) begin
                        $display("%0t: pixel_out expected %0d actual %0d",
                                 $time, e.pixel_out, m_data.pixel_out);
                        errors++;
                    end
                    if (m_data.is_detection !== e.is_detection) begin
                        $display("%0t: is_detection expected %0d actual %0d",
                                 $time, e.is_detection, m_data.is_detection);
                        errors++;
                    end
                    if (m_data.frame_end !== e.frame_end) begin
                        $display("%0t: frame_end expected %0d actual %0d",
                                 $time, e.frame_end, m_data.frame_end);
                        errors++;
                    end
                end
            end
            m_ready <= calm || $urandom_range(99) >= 20;
        end
    end

    // stall watchdog
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    int bg_r, bg_g, bg_b;

    function automatic logic [7:0] rand_chan();
        int p;
        p = $urandom_range(99);
        if (p < 10) return 8'd0;
        if (p < 20) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] near(int base);
        int v;
        v = base + $urandom_range(8) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        in_beat_t x;
        x.op = OP_PIXEL;
        x.red = r;
        x.green = g;
        x.blue = b;
        pixel_queue.insert(pixel_queue.size(), x);
    endtask

    task automatic push_flush();
        in_beat_t x;
        x.op = OP_FLUSH;
        x.red = rand_chan();
        x.green = rand_chan();
        x.blue = rand_chan();
        pixel_queue.insert(pixel_queue.size(), x);
    endtask

    task automatic wait_idle();
        while (pixel_queue.size() > 0 || s_valid || expected_beats.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [9:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_THRESHOLD: thr   = val[7:0];
            CFG_WIDTH:     cfg_w = val;
            CFG_HEIGHT:    cfg_h = val[8:0];
            default: ;
        endcase
    endtask

    // one frame of pixels plus its drain; in a scene frame most pixels hover near the background
    task automatic gen_frame(int w, int h, bit scene, ref int count);
        int n, early_at, drain, p;
        n = w * h;
        early_at = $urandom_range(99) < 10 ? $urandom_range(n - 1, 1) : -1;
        for (int i = 0; i < n; i++) begin
            if (i == early_at) push_flush();
            if (scene && $urandom_range(99) < 80)
                push_pixel(near(bg_r), near(bg_g), near(bg_b));
            else
                push_pixel(rand_chan(), rand_chan(), rand_chan());
        end
        count += n;
        p = $urandom_range(99);
        if (p < 80) drain = w + 1;
        else if (p < 90) drain = $urandom_range(w);
        else drain = w + 1 + $urandom_range(3, 1);
        repeat (drain) push_flush();
    endtask

    // true when the next k frames only read history already written
    function automatic bit history_ready(int w, int h, int k);
        int s0, sl;
        s0 = (row_ct != 0 || col_ct != 0) ? (slot + 1) % HIST : slot;
        for (int j = 0; j < k; j++) begin
            sl = (s0 + j) % HIST;
            for (int r = 0; r < h; r++)
                for (int c = 0; c < w; c++)
                    if (!history.exists(sl * NPIX + r * COLS + c)) return 1'b0;
        end
        return 1'b1;
    endfunction

    initial begin
        int count, w, h, k, phases;
        count = 0;
        phases = 0;
        seen_frames = 0;
        slot = 0;
        row_ct = 0;
        col_ct = 0;
        for (int i = 0; i < 9; i++) win[i] = '0;
        thr = THR_RST;
        cfg_w = WIDTH_RST;
        cfg_h = HEIGHT_RST;
        fw = clampd(cfg_w, COLS);
        fh = clampd(cfg_h, ROWS);
        bg_r = $urandom_range(200, 40);
        bg_g = $urandom_range(200, 40);
        bg_b = $urandom_range(200, 40);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // tallest frame, sizes clamped from out-of-range writes, no idling
        write_reg(CFG_SPARE, 10'h3ff);
        write_reg(CFG_WIDTH, 10'd0);
        write_reg(CFG_HEIGHT, 10'd511);
        calm = 1'b1;
        gen_frame(3, ROWS, 1'b1, count);
        wait_idle();
        calm = 1'b0;

        // color extremes at the head of a small frame
        write_reg(CFG_WIDTH, 10'd8);
        write_reg(CFG_HEIGHT, 10'd3);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd255, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd0, 8'd255);
        push_pixel(8'd170, 8'd85, 8'd170);
        push_pixel(8'd85, 8'd170, 8'd85);
        for (int i = 0; i < 17; i++) push_pixel(near(bg_r), near(bg_g), near(bg_b));
        repeat (9) push_flush();
        wait_idle();

        // remaining warmup frames at assorted sizes
        for (int f = 2; f < HIST; f += 2) begin
            w = $urandom_range(8, 3);
            h = $urandom_range(6, 3);
            write_reg(CFG_WIDTH, 10'(w));
            write_reg(CFG_HEIGHT, 10'(h));
            gen_frame(w, h, 1'b1, count);
            gen_frame(w, h, 1'b1, count);
            wait_idle();
        end

        // detection phases, threshold extremes and an out-of-range write first
        while (count < 1800 || phases < 4) begin
            if (phases == 0) write_reg(CFG_THRESHOLD, 10'd0);
            else if (phases == 1) write_reg(CFG_THRESHOLD, 10'd255);
            else if (phases == 2) write_reg(CFG_THRESHOLD, 10'd640);
            else write_reg(CFG_THRESHOLD, 10'($urandom_range(40)));
            w = $urandom_range(8, 3);
            h = $urandom_range(6, 3);
            k = $urandom_range(3, 1);
            if (!history_ready(w, h, k)) begin
                w = 3;
                h = 3;
            end
            write_reg(CFG_WIDTH, 10'(w));
            write_reg(CFG_HEIGHT, 10'(h));
            for (int j = 0; j < k; j++) gen_frame(w, h, $urandom_range(99) < 60, count);
            wait_idle();
            phases++;
        end

        wait_idle();
        $display("closed %0d frames; checked %0d result beats, %0d of them marked motion",
                 frames_closed, checked, detections);
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/bsmt_pkg.sv
hw/rtl/background_subtract_median_threshold.sv
tb/sv/tb_background_subtract_median_threshold.sv
